// ===== design/dmx_pkg.sv =====
package dmx_pkg;

  // Field widths
  localparam int AXIS_W   = 8;
  localparam int SHAPE_W  = AXIS_W + 1;
  localparam int MIX_W    = 17;
  localparam int MAG_W    = MIX_W - 1;
  localparam int CMD_W    = 8;
  localparam int SPEED_W  = 16;

  // Scale factors applied before the division: x*128 - x and x << 14.
  localparam int CMD_SHIFT   = 7;
  localparam int SPEED_SHIFT = 14;
  localparam int DVD_W       = MAG_W + SPEED_SHIFT;
  // The quotient never exceeds 16384 once the numerator is at most the divisor.
  localparam int Q_W         = SPEED_SHIFT + 1;
  localparam int DIV_STEPS   = Q_W;

  // Queue between the classifier and the divider pipeline (power of two).
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIX_MODE      = 1'b0,
    CFG_SQUARE_ENABLE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_ARCADE    = 2'd0,
    MODE_CURVATURE = 2'd1,
    MODE_TANK      = 2'd2
  } mix_mode_t;

  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic signed [SHAPE_W-1:0] shape_t;
  typedef logic signed [MIX_W-1:0]   mix_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic signed [CMD_W-1:0]   cmd_t;
  typedef logic signed [SPEED_W-1:0] speed_t;

  // Full-scale denominators of each mode.
  localparam mag_t D_ARCADE    = mag_t'(254);
  localparam mag_t D_CURVATURE = mag_t'(16129);
  localparam mag_t D_TANK      = mag_t'(127);

  // One classified item: magnitudes already limited to the divisor, plus signs.
  typedef struct packed {
    mag_t d;
    mag_t mag_l;
    mag_t mag_r;
    logic neg_lc;
    logic neg_rc;
    logic neg_ls;
    logic neg_rs;
  } job_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } q_stat_t;

  // Signed squaring a*|a|/127, truncated toward zero, for every axis code.
  typedef shape_t sq_tab_t [2**AXIS_W];

  function automatic sq_tab_t build_sq_tab();
    sq_tab_t tab;
    int      v;
    for (int i = 0; i < 2**AXIS_W; i++) begin
      v = (i < 2**(AXIS_W-1)) ? i : i - 2**AXIS_W;
      tab[i] = SHAPE_W'((v * ((v < 0) ? -v : v)) / 127);
    end
    return tab;
  endfunction

  localparam sq_tab_t SQ_TAB = build_sq_tab();

endpackage

// ===== design/dmx_in_if.sv =====
interface dmx_in_if
  import dmx_pkg::*;
();
  logic  valid;
  logic  ready;
  axis_t stick_left_y;
  axis_t stick_right_x;
  axis_t stick_right_y;

  modport source (output valid, output stick_left_y, output stick_right_x,
                  output stick_right_y, input ready);
  modport sink   (input valid, input stick_left_y, input stick_right_x,
                  input stick_right_y, output ready);
endinterface

// ===== design/dmx_out_if.sv =====
interface dmx_out_if
  import dmx_pkg::*;
();
  logic   valid;
  logic   ready;
  cmd_t   left_motor_cmd;
  cmd_t   right_motor_cmd;
  speed_t left_wheel_speed;
  speed_t right_wheel_speed;

  modport source (output valid, output left_motor_cmd, output right_motor_cmd,
                  output left_wheel_speed, output right_wheel_speed, input ready);
  modport sink   (input valid, input left_motor_cmd, input right_motor_cmd,
                  input left_wheel_speed, input right_wheel_speed, output ready);
endinterface

// ===== design/dmx_front.sv =====
module dmx_front
  import dmx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dmx_in_if.sink                in_ch,
  input  q_stat_t               q_stat,
  output logic                  push_valid,
  output job_t                  push_job
);

  mix_mode_t mix_mode_r, mix_mode_nxt;
  logic      square_enable_r, square_enable_nxt;

  logic      va_r, va_nxt;
  shape_t    s_a_r, s_a_nxt, r_a_r, r_a_nxt, t_a_r, t_a_nxt;
  mix_mode_t mode_a_r;

  logic      vb_r, vb_nxt;
  mix_t      l_b_r, l_b_nxt, rt_b_r, rt_b_nxt;
  mix_mode_t mode_b_r;

  logic      vc_r, vc_nxt;
  job_t      job_c_r, job_c_nxt;

  logic [QCNT_W-1:0] occupied;

  // Configuration registers
  always_comb begin
    mix_mode_nxt      = mix_mode_r;
    square_enable_nxt = square_enable_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MIX_MODE:      mix_mode_nxt = mix_mode_t'(cfg_data[1:0]);
        CFG_SQUARE_ENABLE: square_enable_nxt = cfg_data[0];
        default:           ;
      endcase
    end
  end

  // Every item in the front stages owns a queue slot, so a push never overflows.
  assign occupied = q_stat.count + QCNT_W'(va_r) + QCNT_W'(vb_r) + QCNT_W'(vc_r);
  assign in_ch.ready = occupied < QCNT_W'(QDEPTH);

  // Stage A: axis shaping
  always_comb begin
    va_nxt  = in_ch.valid && in_ch.ready;
    s_a_nxt = square_enable_r ? SQ_TAB[in_ch.stick_left_y[AXIS_W-1:0]]
                              : {in_ch.stick_left_y[AXIS_W-1], in_ch.stick_left_y};
    r_a_nxt = square_enable_r ? SQ_TAB[in_ch.stick_right_x[AXIS_W-1:0]]
                              : {in_ch.stick_right_x[AXIS_W-1], in_ch.stick_right_x};
    t_a_nxt = square_enable_r ? SQ_TAB[in_ch.stick_right_y[AXIS_W-1:0]]
                              : {in_ch.stick_right_y[AXIS_W-1], in_ch.stick_right_y};
  end

  // Stage B: mixing into left and right numerators
  always_comb begin
    logic signed [SHAPE_W:0]     s_w;
    logic signed [SHAPE_W:0]     r_w;
    logic signed [SHAPE_W:0]     rp;
    logic signed [SHAPE_W:0]     abs_s;
    logic signed [2*SHAPE_W+1:0] prod;
    mix_t                        prod_m;
    mix_t                        s_m;
    mix_t                        r_m;
    mix_t                        t_m;
    mix_t                        s127;
    s_w    = {s_a_r[SHAPE_W-1], s_a_r};
    r_w    = {r_a_r[SHAPE_W-1], r_a_r};
    rp     = (s_a_r > 0) ? -r_w : r_w;
    abs_s  = (s_w < 0) ? -s_w : s_w;
    prod   = abs_s * rp;
    prod_m = prod[MIX_W-1:0];
    s_m    = {{(MIX_W-SHAPE_W){s_a_r[SHAPE_W-1]}}, s_a_r};
    r_m    = {{(MIX_W-SHAPE_W){r_a_r[SHAPE_W-1]}}, r_a_r};
    t_m    = {{(MIX_W-SHAPE_W){t_a_r[SHAPE_W-1]}}, t_a_r};
    s127   = (s_m <<< 7) - s_m;
    vb_nxt = va_r;
    case (mode_a_r)
      MODE_ARCADE: begin
        l_b_nxt  = -r_m - (s_m <<< 1);
        rt_b_nxt = (s_m <<< 1) - r_m;
      end
      MODE_CURVATURE: begin
        l_b_nxt  = s127 - prod_m;
        rt_b_nxt = s127 + prod_m;
      end
      default: begin
        l_b_nxt  = s_m;
        rt_b_nxt = t_m;
      end
    endcase
  end

  // Stage C: common divisor, magnitudes and output signs
  always_comb begin
    mag_t mag_l;
    mag_t mag_r;
    mag_t max_m;
    mag_l  = (l_b_r < 0) ? MAG_W'(-l_b_r) : MAG_W'(l_b_r);
    mag_r  = (rt_b_r < 0) ? MAG_W'(-rt_b_r) : MAG_W'(rt_b_r);
    max_m  = (mag_l > mag_r) ? mag_l : mag_r;
    vc_nxt = vb_r;
    job_c_nxt.mag_l  = mag_l;
    job_c_nxt.mag_r  = mag_r;
    job_c_nxt.neg_ls = l_b_r < 0;
    job_c_nxt.neg_lc = l_b_r < 0;
    job_c_nxt.neg_rs = rt_b_r < 0;
    job_c_nxt.neg_rc = rt_b_r > 0;
    case (mode_b_r)
      MODE_ARCADE: begin
        job_c_nxt.d      = (max_m > D_ARCADE) ? max_m : D_ARCADE;
        job_c_nxt.neg_ls = l_b_r > 0;
        job_c_nxt.neg_lc = l_b_r > 0;
        job_c_nxt.neg_rc = rt_b_r < 0;
      end
      MODE_CURVATURE: begin
        job_c_nxt.d = (max_m > D_CURVATURE) ? max_m : D_CURVATURE;
      end
      default: begin
        // A squared axis of -128 reaches 129; limiting it to the divisor saturates.
        job_c_nxt.d     = D_TANK;
        job_c_nxt.mag_l = (mag_l > D_TANK) ? D_TANK : mag_l;
        job_c_nxt.mag_r = (mag_r > D_TANK) ? D_TANK : mag_r;
      end
    endcase
  end

  assign push_valid = vc_r;
  assign push_job   = job_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_mode_r      <= MODE_ARCADE;
      square_enable_r <= 1'b0;
      va_r            <= 1'b0;
      vb_r            <= 1'b0;
      vc_r            <= 1'b0;
    end else begin
      mix_mode_r      <= mix_mode_nxt;
      square_enable_r <= square_enable_nxt;
      va_r            <= va_nxt;
      vb_r            <= vb_nxt;
      vc_r            <= vc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_a_r    <= s_a_nxt;
    r_a_r    <= r_a_nxt;
    t_a_r    <= t_a_nxt;
    mode_a_r <= mix_mode_r;
    l_b_r    <= l_b_nxt;
    rt_b_r   <= rt_b_nxt;
    mode_b_r <= mode_a_r;
    job_c_r  <= job_c_nxt;
  end

endmodule

// ===== design/dmx_queue.sv =====
module dmx_queue
  import dmx_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    pop_job,
  output q_stat_t q_stat
);

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_valid);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(push_valid) - QCNT_W'(pop);
  end

  assign pop_job      = mem_r[rd_ptr_r];
  assign q_stat.count = count_r;
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== design/dmx_back.sv =====
module dmx_back
  import dmx_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  q_stat_t q_stat,
  input  job_t    pop_job,
  output logic    pop,
  dmx_out_if.source out_ch
);

  localparam int LANES   = 4;
  localparam int LANE_LC = 0;
  localparam int LANE_RC = 1;
  localparam int LANE_LS = 2;
  localparam int LANE_RS = 3;

  // One restoring division step per stage, four lanes sharing a divisor.
  mag_t             rem_r [DIV_STEPS+1][LANES];
  mag_t             rem_nxt [DIV_STEPS+1][LANES];
  logic [Q_W-1:0]   lo_r [DIV_STEPS+1][LANES];
  logic [Q_W-1:0]   lo_nxt [DIV_STEPS+1][LANES];
  logic [Q_W-1:0]   quo_r [DIV_STEPS+1][LANES];
  logic [Q_W-1:0]   quo_nxt [DIV_STEPS+1][LANES];
  mag_t             d_r [DIV_STEPS+1];
  mag_t             d_nxt [DIV_STEPS+1];
  logic [LANES-1:0] neg_r [DIV_STEPS+1];
  logic [LANES-1:0] neg_nxt [DIV_STEPS+1];
  logic [DIV_STEPS:0] v_r, v_nxt;

  logic   out_valid_r, out_valid_nxt;
  cmd_t   out_lc_r, out_lc_nxt, out_rc_r, out_rc_nxt;
  speed_t out_ls_r, out_ls_nxt, out_rs_r, out_rs_nxt;
  logic   adv;

  // The whole pipeline moves unless a finished beat is held at the output.
  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && !q_stat.empty;

  always_comb begin
    mag_t             mag;
    logic [DVD_W-1:0] x;
    logic [MAG_W:0]   trial;
    logic             ge;
    d_nxt[0]   = pop_job.d;
    neg_nxt[0] = {pop_job.neg_rs, pop_job.neg_ls, pop_job.neg_rc, pop_job.neg_lc};
    v_nxt[0]   = !q_stat.empty;
    for (int k = 0; k < LANES; k++) begin
      mag = (k == LANE_LC || k == LANE_LS) ? pop_job.mag_l : pop_job.mag_r;
      if (k == LANE_LC || k == LANE_RC) begin
        x = (DVD_W'(mag) << CMD_SHIFT) - DVD_W'(mag);
      end else begin
        x = DVD_W'(mag) << SPEED_SHIFT;
      end
      rem_nxt[0][k] = MAG_W'(x[DVD_W-1:Q_W]);
      lo_nxt[0][k]  = x[Q_W-1:0];
      quo_nxt[0][k] = '0;
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      d_nxt[j+1]   = d_r[j];
      neg_nxt[j+1] = neg_r[j];
      v_nxt[j+1]   = v_r[j];
      for (int k = 0; k < LANES; k++) begin
        trial = {rem_r[j][k], lo_r[j][k][Q_W-1]};
        ge    = trial >= {1'b0, d_r[j]};
        rem_nxt[j+1][k] = ge ? MAG_W'(trial - {1'b0, d_r[j]}) : MAG_W'(trial);
        lo_nxt[j+1][k]  = lo_r[j][k] << 1;
        quo_nxt[j+1][k] = {quo_r[j][k][Q_W-2:0], ge};
      end
    end
  end

  // Output register: quotient magnitudes take their signs here.
  always_comb begin
    cmd_t   lc;
    cmd_t   rc;
    speed_t ls;
    speed_t rs;
    lc = CMD_W'(quo_r[DIV_STEPS][LANE_LC]);
    rc = CMD_W'(quo_r[DIV_STEPS][LANE_RC]);
    ls = SPEED_W'(quo_r[DIV_STEPS][LANE_LS]);
    rs = SPEED_W'(quo_r[DIV_STEPS][LANE_RS]);
    out_valid_nxt = v_r[DIV_STEPS];
    out_lc_nxt    = neg_r[DIV_STEPS][LANE_LC] ? -lc : lc;
    out_rc_nxt    = neg_r[DIV_STEPS][LANE_RC] ? -rc : rc;
    out_ls_nxt    = neg_r[DIV_STEPS][LANE_LS] ? -ls : ls;
    out_rs_nxt    = neg_r[DIV_STEPS][LANE_RS] ? -rs : rs;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.left_motor_cmd    = out_lc_r;
  assign out_ch.right_motor_cmd   = out_rc_r;
  assign out_ch.left_wheel_speed  = out_ls_r;
  assign out_ch.right_wheel_speed = out_rs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r    <= rem_nxt;
      lo_r     <= lo_nxt;
      quo_r    <= quo_nxt;
      d_r      <= d_nxt;
      neg_r    <= neg_nxt;
      out_lc_r <= out_lc_nxt;
      out_rc_r <= out_rc_nxt;
      out_ls_r <= out_ls_nxt;
      out_rs_r <= out_rs_nxt;
    end
  end

endmodule

// ===== design/differential_drive_mixer_top.sv =====
// Differential drive mixer: each beat on in_ch carries three joystick axes and yields exactly
// one beat on out_ch with both motor commands and both Q14 wheel speeds, in order. The block
// takes one beat per clock and delivers one per clock while out_ch is ready. A result passes
// through 21 register stages, the first loaded at the edge that accepts its input beat: three
// classifying stages, one queue slot, a load stage, fifteen restoring division steps at one
// quotient bit per stage, and the output register. An eight-entry queue separates the
// classifying front from the divider. While a result is held at the output, up to eight input
// beats, counting those still in the front stages, are still taken before in_ch stalls.
// mix_mode (index 0) and square_enable (index 1) are written through the cfg_ port and take
// effect for beats accepted after the write; mode code 3 behaves as tank.
module differential_drive_mixer_top
  import dmx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dmx_in_if.sink                in_ch,
  dmx_out_if.source             out_ch
);

  logic    push_valid;
  job_t    push_job;
  logic    pop;
  job_t    pop_job;
  q_stat_t q_stat;

  dmx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .q_stat     (q_stat),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  dmx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .pop        (pop),
    .pop_job    (pop_job),
    .q_stat     (q_stat)
  );

  dmx_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .pop_job (pop_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== dv/drive_mix_checker.sv =====
`timescale 1ns / 100ps

module drive_mix_checker
  import dmx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  dmx_in_if                     in_mon,
  dmx_out_if                    out_mon,
  output int                    mismatches,
  output int                    cmds_outstanding
);

  typedef struct packed {
    cmd_t   left_cmd;
    cmd_t   right_cmd;
    speed_t left_q14;
    speed_t right_q14;
  } drive_cmd_t;

  logic [1:0] mode_q;
  logic       square_q;
  drive_cmd_t drive_cmds_q[$];

  initial begin
    mismatches       = 0;
    cmds_outstanding = 0;
  end

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint shape_axis(longint a, logic sq);
    return sq ? (a * abs_l(a)) / 127 : a;
  endfunction

  // The full-scale value k is also the saturation limit for both output kinds.
  function automatic longint scale_sat(longint n, longint d, longint k);
    longint q;
    q = (n * k) / d;
    if (q > k) q = k;
    if (q < -k) q = -k;
    return q;
  endfunction

  function automatic drive_cmd_t predict_drive(logic [1:0] mode, logic sq,
                                               axis_t ly, axis_t rx, axis_t ry);
    drive_cmd_t res;
    longint s, r, t, l, rt, rp, m, d;
    longint n_ls, n_rs, n_lc, n_rc;
    s = shape_axis(longint'(ly), sq);
    r = shape_axis(longint'(rx), sq);
    t = shape_axis(longint'(ry), sq);
    case (mode)
      MODE_ARCADE: begin
        l  = -r - 2 * s;
        rt = 2 * s - r;
        m  = (abs_l(l) > abs_l(rt)) ? abs_l(l) : abs_l(rt);
        d  = (m > 254) ? m : 254;
        n_ls = -l;
        n_lc = -l;
        n_rs = rt;
        n_rc = rt;
      end
      MODE_CURVATURE: begin
        // Rotation flips sign when driving forward.
        rp = (s > 0) ? -r : r;
        l  = 127 * s - abs_l(s) * rp;
        rt = 127 * s + abs_l(s) * rp;
        m  = (abs_l(l) > abs_l(rt)) ? abs_l(l) : abs_l(rt);
        d  = (m > 16129) ? m : 16129;
        n_ls = l;
        n_lc = l;
        n_rs = rt;
        n_rc = -rt;
      end
      default: begin
        d    = 127;
        n_ls = s;
        n_lc = s;
        n_rs = t;
        n_rc = -t;
      end
    endcase
    res.left_cmd  = cmd_t'(scale_sat(n_lc, d, 127));
    res.right_cmd = cmd_t'(scale_sat(n_rc, d, 127));
    res.left_q14  = speed_t'(scale_sat(n_ls, d, 16384));
    res.right_q14 = speed_t'(scale_sat(n_rs, d, 16384));
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    drive_cmd_t want;
    if (!rst_n) begin
      mode_q   <= MODE_ARCADE;
      square_q <= 1'b0;
      drive_cmds_q.delete();
    end else begin
      // A register write only affects beats accepted after this edge.
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MIX_MODE:      mode_q   <= cfg_data;
          CFG_SQUARE_ENABLE: square_q <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        drive_cmds_q.push_back(predict_drive(mode_q, square_q, in_mon.stick_left_y,
                                             in_mon.stick_right_x, in_mon.stick_right_y));
      if (out_mon.valid && out_mon.ready) begin
        if (drive_cmds_q.size() == 0) begin
          report_mismatch("result beat arrived with nothing expected");
        end else begin
          want = drive_cmds_q.pop_front();
          check_field("left_motor_cmd", out_mon.left_motor_cmd, want.left_cmd);
          check_field("right_motor_cmd", out_mon.right_motor_cmd, want.right_cmd);
          check_field("left_wheel_speed", out_mon.left_wheel_speed, want.left_q14);
          check_field("right_wheel_speed", out_mon.right_wheel_speed, want.right_q14);
        end
      end
    end
    cmds_outstanding <= drive_cmds_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import dmx_pkg::*;

  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int         QUIET_LIMIT = 4000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         PHASE_BEATS = 52;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int cmds_outstanding;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;
  int quiet_cycles;

  dmx_in_if  in_ch ();
  dmx_out_if out_ch ();

  differential_drive_mixer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  drive_mix_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .mismatches       (mismatches),
    .cmds_outstanding (cmds_outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random back-pressure, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold      <= rx_hold - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic axis_t pick_axis();
    axis_t edges[6] = '{-8'sd128, -8'sd127, -8'sd1, 8'sd0, 8'sd1, 8'sd127};
    if ($urandom_range(3) == 0)
      return edges[$urandom_range(5)];
    return axis_t'($urandom);
  endfunction

  // Called and returns at a falling edge.
  task automatic send_sample(axis_t ly, axis_t rx, axis_t ry);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.stick_left_y  <= ly;
    in_ch.stick_right_x <= rx;
    in_ch.stick_right_y <= ry;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Registers change only once every outstanding result has been delivered.
  task automatic apply_setting(int idx);
    logic [1:0] modes[4] = '{MODE_ARCADE, MODE_CURVATURE, MODE_TANK, MODE_SPARE};
    in_ch.valid <= 1'b0;
    while (cmds_outstanding != 0) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MIX_MODE;
    cfg_data  <= modes[idx / 2];
    @(negedge clk);
    cfg_index <= CFG_SQUARE_ENABLE;
    cfg_data  <= CFG_DATA_W'(idx % 2);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    axis_t directed[8][3] = '{
      '{8'sd127, 8'sd0, 8'sd0}, '{-8'sd127, 8'sd0, 8'sd0},
      '{8'sd0, 8'sd127, 8'sd0}, '{8'sd0, -8'sd127, 8'sd127},
      '{8'sd127, 8'sd127, -8'sd127}, '{-8'sd128, -8'sd128, -8'sd128},
      '{8'sd127, -8'sd127, 8'sd127}, '{-8'sd127, 8'sd127, 8'sd0}
    };
    int sel;
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_index           = CFG_MIX_MODE;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.stick_left_y  = '0;
    in_ch.stick_right_x = '0;
    in_ch.stick_right_y = '0;
    out_ch.ready        = 1'b0;
    tx_idle_pct         = 33;
    rx_idle_pct         = 49;
    rx_hold             = 0;
    quiet_cycles        = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Extremes and saturation under every mode and squaring setting; the -128 code under three of them.
    for (int k = 0; k < 8; k++) begin
      apply_setting(k);
      for (int j = 0; j < 3; j++) begin
        sel = (3 * k + j) % 8;
        send_sample(directed[sel][0], directed[sel][1], directed[sel][2]);
      end
    end

    for (int sched = 0; sched < 3; sched++) begin
      tx_idle_pct = (sched == 0) ? 33 : (sched == 1) ? 49 : 0;
      rx_idle_pct = (sched == 0) ? 49 : (sched == 1) ? 33 : 0;
      for (int k = 0; k < 8; k++) begin
        apply_setting(k);
        // Stall the result side long enough for the internal queue to fill up.
        if (sched == 2 && k == 0) rx_hold = HOLD_CYCLES;
        repeat (PHASE_BEATS) send_sample(pick_axis(), pick_axis(), pick_axis());
      end
    end

    in_ch.valid <= 1'b0;
    while (cmds_outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && cmds_outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/dmx_pkg.sv
design/dmx_in_if.sv
design/dmx_out_if.sv
design/dmx_front.sv
design/dmx_queue.sv
design/dmx_back.sv
design/differential_drive_mixer_top.sv
dv/drive_mix_checker.sv
dv/tb_top.sv
